@@ src/lwsf_pkg.sv @@
package lwsf_pkg;

  localparam int unsigned DIMS_W    = 2;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NUM_LANES = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ITEM_WIDTH  = 2'd0,
    CFG_MAX_ITEM_HEIGHT = 2'd1,
    CFG_MAX_ITEM_DEPTH  = 2'd2,
    CFG_MAX_GROUP_ITEMS = 2'd3
  } cfg_idx_e;

  // Control from the top level to one GCD lane
  typedef struct packed {
    logic start;
    logic used;
  } lane_ctrl_t;

  // Control from the top level to the group-limit fit stage
  typedef struct packed {
    logic start;
    logic ack;
  } fit_ctrl_t;

endpackage

@@ src/lwsf_if.sv @@
interface lwsf_in_if #(
  parameter int unsigned GLOBAL_BITS = 32
);
  logic                           valid;
  logic                           ready;
  logic [lwsf_pkg::DIMS_W-1:0]    dims_used;
  logic [GLOBAL_BITS-1:0]         global_width;
  logic [GLOBAL_BITS-1:0]         global_height;
  logic [GLOBAL_BITS-1:0]         global_depth;

  modport source (
    output valid, dims_used, global_width, global_height, global_depth,
    input  ready
  );
  modport sink (
    input  valid, dims_used, global_width, global_height, global_depth,
    output ready
  );
endinterface

interface lwsf_out_if;
  logic                           valid;
  logic                           ready;
  logic [lwsf_pkg::DIMS_W-1:0]    out_dims;
  logic [lwsf_pkg::SIZE_W-1:0]    local_width;
  logic [lwsf_pkg::SIZE_W-1:0]    local_height;
  logic [lwsf_pkg::SIZE_W-1:0]    local_depth;

  modport source (
    output valid, out_dims, local_width, local_height, local_depth,
    input  ready
  );
  modport sink (
    input  valid, out_dims, local_width, local_height, local_depth,
    output ready
  );
endinterface

interface lwsf_cfg_if #(
  parameter int unsigned LIMIT_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic [lwsf_pkg::CFG_IDX_W-1:0] idx;
  logic [LIMIT_BITS-1:0]          data;

  modport source (
    output valid, idx, data,
    input  ready
  );
  modport sink (
    input  valid, idx, data,
    output ready
  );
endinterface

@@ src/lwsf_gcd_lane.sv @@
module lwsf_gcd_lane #(
  parameter int unsigned GLOBAL_BITS = 32,
  parameter int unsigned LIMIT_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lwsf_pkg::lane_ctrl_t       ctrl_i,
  input  logic [GLOBAL_BITS-1:0]     a_i,
  input  logic [LIMIT_BITS-1:0]      b_i,
  output logic                       done_o,
  output logic [LIMIT_BITS-1:0]      res_o
);

  localparam int unsigned UW = (GLOBAL_BITS > LIMIT_BITS) ? GLOBAL_BITS : LIMIT_BITS;
  localparam int unsigned KW = $clog2(LIMIT_BITS);

  typedef enum logic [1:0] {
    L_IDLE,
    L_RUN,
    L_DONE
  } lane_state_e;

  lane_state_e           state_q;
  logic [UW-1:0]         u_q;
  logic [LIMIT_BITS-1:0] v_q;
  logic [KW-1:0]         k_q;
  logic [LIMIT_BITS-1:0] res_q;
  logic [UW-1:0]         v_ext;

  assign v_ext  = UW'(v_q);
  assign done_o = (state_q == L_DONE);
  assign res_o  = res_q;

  // Binary GCD: one shift or one subtract per cycle; v never reaches zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      u_q     <= '0;
      v_q     <= '0;
      k_q     <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        L_IDLE, L_DONE: begin
          if (ctrl_i.start) begin
            if (ctrl_i.used) begin
              u_q     <= UW'(a_i);
              v_q     <= b_i;
              k_q     <= '0;
              state_q <= L_RUN;
            end else begin
              res_q   <= LIMIT_BITS'(1);
              state_q <= L_DONE;
            end
          end
        end
        L_RUN: begin
          priority if (u_q == '0) begin
            res_q   <= v_q << k_q;
            state_q <= L_DONE;
          end else if (!u_q[0] && !v_q[0]) begin
            u_q <= u_q >> 1;
            v_q <= v_q >> 1;
            k_q <= k_q + 1'b1;
          end else if (!u_q[0]) begin
            u_q <= u_q >> 1;
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
          end else if (u_q >= v_ext) begin
            u_q <= u_q - v_ext;
          end else begin
            // swap so the larger odd value is reduced
            u_q <= v_ext - u_q;
            v_q <= u_q[LIMIT_BITS-1:0];
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == L_RUN) |-> (v_q != '0))
    else $error("gcd lane divisor reached zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == L_DONE) |-> (res_q != '0))
    else $error("gcd lane finished with a zero result");
`endif

endmodule

@@ src/lwsf_fit.sv @@
module lwsf_fit #(
  parameter int unsigned LIMIT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lwsf_pkg::fit_ctrl_t     ctrl_i,
  input  logic [LIMIT_BITS-1:0]   lim_i,
  input  logic [LIMIT_BITS-1:0]   w_i,
  input  logic [LIMIT_BITS-1:0]   h_i,
  input  logic [LIMIT_BITS-1:0]   d_i,
  output logic                    done_o,
  output logic [LIMIT_BITS-1:0]   w_o,
  output logic [LIMIT_BITS-1:0]   h_o,
  output logic [LIMIT_BITS-1:0]   d_o
);

  localparam int unsigned PW = 2 * LIMIT_BITS;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_CHK1,
    F_CHK2,
    F_DONE
  } fit_state_e;

  fit_state_e            state_q;
  logic [LIMIT_BITS-1:0] w_q, h_q, d_q;
  logic [PW-1:0]         prod_q;
  logic [LIMIT_BITS-1:0] mul_x, mul_y;
  logic [PW-1:0]         mul_res;
  logic [PW-1:0]         lim_ext;

  function automatic logic [LIMIT_BITS-1:0] halve(input logic [LIMIT_BITS-1:0] v);
    halve = (v > LIMIT_BITS'(1)) ? (v >> 1) : LIMIT_BITS'(1);
  endfunction

  // One shared multiplier: w*h first, then (w*h)*d once w*h fits the limit
  assign mul_x   = (state_q == F_CHK1) ? prod_q[LIMIT_BITS-1:0] : w_q;
  assign mul_y   = (state_q == F_CHK1) ? d_q : h_q;
  assign mul_res = PW'(mul_x) * PW'(mul_y);
  assign lim_ext = PW'(lim_i);

  assign done_o = (state_q == F_DONE);
  assign w_o    = w_q;
  assign h_o    = h_q;
  assign d_o    = d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      w_q     <= '0;
      h_q     <= '0;
      d_q     <= '0;
      prod_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (ctrl_i.start) begin
            w_q     <= w_i;
            h_q     <= h_i;
            d_q     <= d_i;
            state_q <= (lim_i == '0) ? F_DONE : F_MUL;
          end
        end
        F_MUL: begin
          prod_q  <= mul_res;
          state_q <= F_CHK1;
        end
        F_CHK1: begin
          if (prod_q > lim_ext) begin
            w_q     <= halve(w_q);
            h_q     <= halve(h_q);
            d_q     <= halve(d_q);
            state_q <= F_MUL;
          end else begin
            prod_q  <= mul_res;
            state_q <= F_CHK2;
          end
        end
        F_CHK2: begin
          if (prod_q > lim_ext) begin
            w_q     <= halve(w_q);
            h_q     <= halve(h_q);
            d_q     <= halve(d_q);
            state_q <= F_MUL;
          end else begin
            state_q <= F_DONE;
          end
        end
        F_DONE: begin
          if (ctrl_i.ack) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_DONE) |-> (w_q != '0 && h_q != '0 && d_q != '0))
    else $error("fit stage produced a zero local size");
`endif

endmodule

@@ src/local_work_size_fit_unit.sv @@
// Local work-group size fitter.
// Channels: cfg_i writes the four limit registers (index 0..3: max width,
// max height, max depth, max group items; zero group limit = unlimited) and
// is always ready. in_i carries one global work size per transaction; out_o
// returns one local size per transaction, with out_dims equal to the input's
// dimension count (1 when the count is zero).
// Processing: three GCD lanes run side by side, one binary GCD step per cycle;
// then the fit stage runs its halving rounds on its one shared multiplier,
// at most LIMIT_BITS rounds.
// Throughput: one transaction at a time; in_i is ready again once the result
// sits in the output register, so a new item runs while out_o is stalled.
// A stalled out_o holds its result; a finished item then waits in the fit
// stage until the output register frees up.
// Reset: limits return to 1, 1, 1 and group limit 0; no result is pending.
module local_work_size_fit_unit #(
  parameter int unsigned GLOBAL_BITS = 32,
  parameter int unsigned LIMIT_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lwsf_cfg_if.sink    cfg_i,
  lwsf_in_if.sink     in_i,
  lwsf_out_if.source  out_o
);

  localparam int unsigned NL = lwsf_pkg::NUM_LANES;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GCD,
    S_FIT
  } state_e;

  state_e                          state_q;
  logic [lwsf_pkg::DIMS_W-1:0]     dims_q;
  logic                            out_valid_q;
  logic [lwsf_pkg::DIMS_W-1:0]     out_dims_q;
  logic [lwsf_pkg::SIZE_W-1:0]     out_w_q, out_h_q, out_d_q;

  logic [LIMIT_BITS-1:0]           max_w_q, max_h_q, max_d_q, max_grp_q;

  lwsf_pkg::lane_ctrl_t            lane_ctrl [NL];
  logic [GLOBAL_BITS-1:0]          lane_a    [NL];
  logic [LIMIT_BITS-1:0]           lane_b    [NL];
  logic [LIMIT_BITS-1:0]           lane_res  [NL];
  logic [NL-1:0]                   lane_done;

  lwsf_pkg::fit_ctrl_t             fit_ctrl;
  logic                            fit_done;
  logic [LIMIT_BITS-1:0]           fit_w, fit_h, fit_d;

  logic in_acc, out_acc, out_free, load_out;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_w_q   <= LIMIT_BITS'(1);
      max_h_q   <= LIMIT_BITS'(1);
      max_d_q   <= LIMIT_BITS'(1);
      max_grp_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (lwsf_pkg::cfg_idx_e'(cfg_i.idx))
        lwsf_pkg::CFG_MAX_ITEM_WIDTH:  max_w_q   <= cfg_i.data;
        lwsf_pkg::CFG_MAX_ITEM_HEIGHT: max_h_q   <= cfg_i.data;
        lwsf_pkg::CFG_MAX_ITEM_DEPTH:  max_d_q   <= cfg_i.data;
        lwsf_pkg::CFG_MAX_GROUP_ITEMS: max_grp_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_valid_q && out_o.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign load_out   = (state_q == S_FIT) && fit_done && out_free;

  // A zero maximum counts as 1
  assign lane_a[0] = in_i.global_width;
  assign lane_a[1] = in_i.global_height;
  assign lane_a[2] = in_i.global_depth;
  assign lane_b[0] = (max_w_q == '0) ? LIMIT_BITS'(1) : max_w_q;
  assign lane_b[1] = (max_h_q == '0) ? LIMIT_BITS'(1) : max_h_q;
  assign lane_b[2] = (max_d_q == '0) ? LIMIT_BITS'(1) : max_d_q;

  for (genvar i = 0; i < NL; i++) begin : g_lane
    assign lane_ctrl[i].start = in_acc;
    assign lane_ctrl[i].used  = (in_i.dims_used > lwsf_pkg::DIMS_W'(i));

    lwsf_gcd_lane #(
      .GLOBAL_BITS (GLOBAL_BITS),
      .LIMIT_BITS  (LIMIT_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl[i]),
      .a_i    (lane_a[i]),
      .b_i    (lane_b[i]),
      .done_o (lane_done[i]),
      .res_o  (lane_res[i])
    );
  end

  assign fit_ctrl.start = (state_q == S_GCD) && (&lane_done);
  assign fit_ctrl.ack   = load_out;

  lwsf_fit #(
    .LIMIT_BITS (LIMIT_BITS)
  ) u_fit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fit_ctrl),
    .lim_i  (max_grp_q),
    .w_i    (lane_res[0]),
    .h_i    (lane_res[1]),
    .d_i    (lane_res[2]),
    .done_o (fit_done),
    .w_o    (fit_w),
    .h_o    (fit_h),
    .d_o    (fit_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dims_q      <= '0;
      out_valid_q <= 1'b0;
      out_dims_q  <= '0;
      out_w_q     <= '0;
      out_h_q     <= '0;
      out_d_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            dims_q  <= in_i.dims_used;
            state_q <= S_GCD;
          end
        end
        S_GCD: begin
          if (&lane_done) begin
            state_q <= S_FIT;
          end
        end
        S_FIT: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // load the result, or drop it once taken
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_dims_q  <= (dims_q == '0) ? lwsf_pkg::DIMS_W'(1) : dims_q;
        out_w_q     <= lwsf_pkg::SIZE_W'(fit_w);
        out_h_q     <= lwsf_pkg::SIZE_W'(fit_h);
        out_d_q     <= lwsf_pkg::SIZE_W'(fit_d);
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_dims     = out_dims_q;
  assign out_o.local_width  = out_w_q;
  assign out_o.local_height = out_h_q;
  assign out_o.local_depth  = out_d_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fit_done |-> (state_q == S_FIT))
    else $error("fit stage finished outside the fit phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_dims_q != '0))
    else $error("result carries a zero dimension count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_GCD) && (dims_q == $past(in_i.dims_used)))
    else $error("accepted transaction not captured");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [lwsf_pkg::DIMS_W-1:0] dims;
    logic [lwsf_pkg::SIZE_W-1:0] width;
    logic [lwsf_pkg::SIZE_W-1:0] height;
    logic [lwsf_pkg::SIZE_W-1:0] depth;
  } local_size_t;

  typedef struct packed {
    logic [lwsf_pkg::DIMS_W-1:0] dims;
    logic [31:0]                 gw;
    logic [31:0]                 gh;
    logic [31:0]                 gd;
  } work_size_t;

  logic clk_i;
  logic rst_ni;

  lwsf_cfg_if #(.LIMIT_BITS(16))  cfg_bus ();
  lwsf_in_if  #(.GLOBAL_BITS(32)) req_bus ();
  lwsf_out_if                     rsp_bus ();

  local_work_size_fit_unit #(
    .GLOBAL_BITS(32),
    .LIMIT_BITS (16)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (req_bus),
    .out_o (rsp_bus)
  );

  // Local copy of the limit registers
  logic [lwsf_pkg::SIZE_W-1:0] max_w;
  logic [lwsf_pkg::SIZE_W-1:0] max_h;
  logic [lwsf_pkg::SIZE_W-1:0] max_d;
  logic [lwsf_pkg::SIZE_W-1:0] max_group;

  work_size_t  pending_q[$];
  local_size_t fit_q[$];

  bit steady;
  bit req_sent;
  int error_cnt;
  int sizes_sent;
  int sizes_checked;
  int halved_cnt;
  int flat_cnt;
  int setting_cnt;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #25_000_000;
    $display("Timeout with %0d transactions still expected", fit_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint unsigned common_divisor(longint unsigned a, longint unsigned b);
    longint unsigned r;
    if (b == 0) b = 1;
    r = a % b;
    while (r != 0) begin
      a = b;
      b = r;
      r = a % b;
    end
    return b;
  endfunction

  function automatic local_size_t fit_local_size(work_size_t ws);
    longint unsigned w = 1;
    longint unsigned h = 1;
    longint unsigned d = 1;
    local_size_t     res;
    if (ws.dims >= 1) w = common_divisor(ws.gw, max_w);
    if (ws.dims >= 2) h = common_divisor(ws.gh, max_h);
    if (ws.dims >= 3) d = common_divisor(ws.gd, max_d);
    if (max_group != 0 && w * h * d > max_group) halved_cnt++;
    while (max_group != 0 && w * h * d > max_group) begin
      w = (w > 1) ? w >> 1 : 1;
      h = (h > 1) ? h >> 1 : 1;
      d = (d > 1) ? d >> 1 : 1;
    end
    if (ws.dims == 0) flat_cnt++;
    res.dims   = (ws.dims == 0) ? lwsf_pkg::DIMS_W'(1) : ws.dims;
    res.width  = w[lwsf_pkg::SIZE_W-1:0];
    res.height = h[lwsf_pkg::SIZE_W-1:0];
    res.depth  = d[lwsf_pkg::SIZE_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] result %0d: %s is %0d, want %0d", $realtime, sizes_checked, field, got,
             want);
    error_cnt++;
  endtask

  // Predict on each accepted input transaction
  always @(posedge clk_i) begin
    if (rst_ni && req_bus.valid && req_bus.ready) begin
      fit_q.push_back(fit_local_size({req_bus.dims_used, req_bus.global_width,
                                      req_bus.global_height, req_bus.global_depth}));
      req_sent = 1'b1;
      sizes_sent++;
    end
  end

  // Driver: hold until taken, then advance or idle
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_bus.valid || req_sent) begin
        req_sent = 1'b0;
        if (pending_q.size() != 0 && (steady || $urandom_range(99) >= 13)) begin
          {req_bus.dims_used, req_bus.global_width, req_bus.global_height,
           req_bus.global_depth} <= pending_q.pop_front();
          req_bus.valid <= 1'b1;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
      rsp_bus.ready <= steady || ($urandom_range(99) >= 13);
    end
  end

  // Monitor: compare each result transaction against the oldest prediction
  always @(posedge clk_i) begin
    local_size_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (fit_q.size() == 0) begin
        report_mismatch("unexpected result, out_dims", rsp_bus.out_dims, 0);
      end else begin
        want = fit_q.pop_front();
        if (rsp_bus.out_dims !== want.dims)
          report_mismatch("out_dims", rsp_bus.out_dims, want.dims);
        if (rsp_bus.local_width !== want.width)
          report_mismatch("local_width", rsp_bus.local_width, want.width);
        if (rsp_bus.local_height !== want.height)
          report_mismatch("local_height", rsp_bus.local_height, want.height);
        if (rsp_bus.local_depth !== want.depth)
          report_mismatch("local_depth", rsp_bus.local_depth, want.depth);
      end
      sizes_checked++;
    end
  end

  task automatic write_limit(lwsf_pkg::cfg_idx_e idx, logic [lwsf_pkg::SIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.idx   <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      lwsf_pkg::CFG_MAX_ITEM_WIDTH:  max_w     = value;
      lwsf_pkg::CFG_MAX_ITEM_HEIGHT: max_h     = value;
      lwsf_pkg::CFG_MAX_ITEM_DEPTH:  max_d     = value;
      lwsf_pkg::CFG_MAX_GROUP_ITEMS: max_group = value;
      default: ;
    endcase
  endtask

  task automatic write_limits(logic [lwsf_pkg::SIZE_W-1:0] w, logic [lwsf_pkg::SIZE_W-1:0] h,
                              logic [lwsf_pkg::SIZE_W-1:0] d, logic [lwsf_pkg::SIZE_W-1:0] g);
    write_limit(lwsf_pkg::CFG_MAX_ITEM_WIDTH, w);
    write_limit(lwsf_pkg::CFG_MAX_ITEM_HEIGHT, h);
    write_limit(lwsf_pkg::CFG_MAX_ITEM_DEPTH, d);
    write_limit(lwsf_pkg::CFG_MAX_GROUP_ITEMS, g);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
    setting_cnt++;
  endtask

  task automatic queue_size(logic [lwsf_pkg::DIMS_W-1:0] dims, logic [31:0] gw,
                            logic [31:0] gh, logic [31:0] gd);
    pending_q.push_back({dims, gw, gh, gd});
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain();
    while (pending_q.size() != 0 || req_bus.valid || fit_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [lwsf_pkg::SIZE_W-1:0] pick_item_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return lwsf_pkg::SIZE_W'(1);
      2: return '1;
      3: return lwsf_pkg::SIZE_W'(1) << $urandom_range(0, lwsf_pkg::SIZE_W - 1);
      4, 5, 6: return lwsf_pkg::SIZE_W'($urandom_range(2, 1024));
      default: return lwsf_pkg::SIZE_W'($urandom);
    endcase
  endfunction

  function automatic logic [lwsf_pkg::SIZE_W-1:0] pick_group_limit();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2: return lwsf_pkg::SIZE_W'(1);
      3: return '1;
      4, 5, 6, 7: return lwsf_pkg::SIZE_W'($urandom_range(2, 4096));
      default: return lwsf_pkg::SIZE_W'($urandom);
    endcase
  endfunction

  // Bias global sizes toward multiples of the limit so the divisor is nontrivial
  function automatic logic [31:0] pick_global(logic [lwsf_pkg::SIZE_W-1:0] m);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      4, 5, 6, 7: return 32'(m) * $urandom_range(1, 65535);
      8, 9: return 32'(m >> $urandom_range(0, 4)) * $urandom_range(1, 9999);
      10: return $urandom_range(1, 100);
      default: return $urandom << $urandom_range(0, 20);
    endcase
  endfunction

  initial begin
    logic [lwsf_pkg::DIMS_W-1:0] dims;
    rst_ni        = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.idx   = lwsf_pkg::CFG_MAX_ITEM_WIDTH;
    cfg_bus.data  = '0;
    req_bus.valid = 1'b0;
    req_bus.dims_used     = '0;
    req_bus.global_width  = '0;
    req_bus.global_height = '0;
    req_bus.global_depth  = '0;
    rsp_bus.ready = 1'b0;
    max_w     = 1;
    max_h     = 1;
    max_d     = 1;
    max_group = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset limits: every local size collapses to 1
    queue_size(0, '1, '1, '1);
    queue_size(1, '0, '0, '0);
    queue_size(2, '1, 32'd12, '0);
    queue_size(3, '1, '0, 32'h8000_0000);
    drain();

    // Widest limits, no group limit
    write_limits('1, '1, '1, '0);
    queue_size(1, '0, '1, '1);
    queue_size(3, '1, '0, 32'd12345);
    queue_size(2, '0, 32'd98304, '0);
    queue_size(0, 32'd1000, 32'd2000, 32'd3000);
    queue_size(3, '0, '0, '0);
    drain();

    // Zero width limit reads as 1; group limit forces halving
    write_limits('0, 16'd48, '1, '1);
    queue_size(3, '0, '0, '0);
    queue_size(3, 32'd96, 32'd72, '0);
    queue_size(1, '1, '0, '0);
    queue_size(2, 32'd7, 32'd36, '1);
    queue_size(3, 32'd5, 32'd0, 32'd65535);
    drain();

    // Group limit of one halves every dimension down to 1
    write_limits(16'd1024, 16'd1024, 16'd1024, 16'd1);
    queue_size(3, '0, '0, '0);
    queue_size(3, 32'd512, 32'd256, 32'd64);
    queue_size(2, 32'd3072, 32'd1, '0);
    queue_size(1, '0, '1, '1);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      write_limits(pick_item_limit(), pick_item_limit(), pick_item_limit(),
                   pick_group_limit());
      steady = (phase == 5);
      for (int n = 0; n < 157; n++) begin
        dims = ($urandom_range(0, 15) == 0) ? lwsf_pkg::DIMS_W'(0)
                                            : lwsf_pkg::DIMS_W'($urandom_range(1, 3));
        queue_size(dims, pick_global(max_w), pick_global(max_h), pick_global(max_d));
      end
      drain();
      steady = 1'b0;
    end

    repeat (300) @(negedge clk_i);
    $display("Sent %0d work sizes under %0d limit settings; %0d results checked.",
             sizes_sent, setting_cnt, sizes_checked);
    $display("%0d needed group-limit halving, %0d had a zero dimension count, %0d mismatches.",
             halved_cnt, flat_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
